// ===== rtl/core/pedf_pkg.sv =====
// ----------------------------------------------------------------------------
// pedf_pkg
// Shared types, constants and the hash step of the path event filter.
// ----------------------------------------------------------------------------
package pedf_pkg;

  // Ring of recent events.
  localparam int unsigned RECENT_ENTRIES = 24;
  localparam int unsigned SLOT_W = (RECENT_ENTRIES > 1) ? $clog2(RECENT_ENTRIES) : 1;

  // Queue between the hashing front and the ring search.
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // Field widths.
  localparam int unsigned HASH_W = 32;
  localparam int unsigned TIME_W = 40;
  localparam int unsigned WIN_W  = 16;

  // FNV-1a constants and the reset value of the suppression window.
  localparam logic [HASH_W-1:0] FNV_BASIS   = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME   = 32'd16777619;
  localparam logic [WIN_W-1:0]  WINDOW_INIT = 16'd1200;

  // Configuration register indexes.
  localparam logic CFG_ENABLED = 1'b0;
  localparam logic CFG_WINDOW  = 1'b1;

  // One finished path hash waiting for the ring search.
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [TIME_W-1:0] stamp;
  } job_t;

  // States of the ring search.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_COMMIT
  } back_state_e;

  // Fold one byte into the hash: xor, then multiply modulo 2^32.
  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

endpackage

// ===== rtl/core/pedf_front.sv =====
// ----------------------------------------------------------------------------
// pedf_front
// Accepts path bytes, folds them into the hash and queues finished paths.
// ----------------------------------------------------------------------------
module pedf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               enabled_i,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         path_byte_i,
  input  logic               is_last_i,
  input  logic [7:0]         kind_code_i,
  input  logic [39:0]        time_ms_i,
  output logic               job_push_o,
  output pedf_pkg::job_t     job_o,
  input  logic               job_full_i
);
  import pedf_pkg::*;

  logic [HASH_W-1:0] acc_q, acc_d;
  logic [HASH_W-1:0] folded;
  logic              accept;

  // A word is taken whenever the queue has room.
  assign full   = job_full_i;
  assign accept = push && !job_full_i;
  assign folded = fnv_fold(acc_q, path_byte_i);

  // Accumulator restarts from the offset basis after every last byte.
  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      acc_d = is_last_i ? FNV_BASIS : folded;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= FNV_BASIS;
    end else begin
      acc_q <= acc_d;
    end
  end

  // A finished path is queued only while reporting is enabled.
  assign job_push_o  = accept && is_last_i && enabled_i;
  assign job_o.hash  = folded ^ {24'd0, kind_code_i};
  assign job_o.stamp = time_ms_i;

endmodule

// ===== rtl/core/pedf_job_fifo.sv =====
// ----------------------------------------------------------------------------
// pedf_job_fifo
// Short queue of finished path hashes between the front and the ring search.
// ----------------------------------------------------------------------------
module pedf_job_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pedf_pkg::job_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output pedf_pkg::job_t  data_o,
  output logic            valid_o
);
  import pedf_pkg::*;

  job_t                 mem_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [JOB_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [JOB_CNT_W-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == JOB_CNT_W'(JOB_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/pedf_back.sv =====
// ----------------------------------------------------------------------------
// pedf_back
// Searches the ring of recent events one entry a cycle, records new events
// and holds the result word until it is popped.
// ----------------------------------------------------------------------------
module pedf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          window_i,
  input  logic                 job_valid_i,
  input  pedf_pkg::job_t       job_i,
  output logic                 job_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output logic                 report_o,
  output logic [31:0]          event_hash_o
);
  import pedf_pkg::*;

  back_state_e       state_q, state_d;
  job_t              job_q;
  logic [SLOT_W-1:0] idx_q;
  logic [SLOT_W-1:0] slot_q;
  logic              dup_q;
  logic              out_valid_q;
  logic              report_q;
  logic [HASH_W-1:0] hash_out_q;
  logic [HASH_W-1:0] ring_hash_q [RECENT_ENTRIES];
  logic [TIME_W-1:0] ring_time_q [RECENT_ENTRIES];

  logic              scan_en, commit, ring_wr, last_idx, out_free;
  logic              hit;
  logic [TIME_W-1:0] st, age;

  assign last_idx = (idx_q == SLOT_W'(RECENT_ENTRIES - 1));
  assign out_free = !out_valid_q || pop;

  // Compare of the current ring entry; a stored time in the future is age zero,
  // which lies inside any window except an empty one.
  assign st  = ring_time_q[idx_q];
  assign age = job_q.stamp - st;
  assign hit = (ring_hash_q[idx_q] == job_q.hash) &&
               ((st > job_q.stamp) ? (window_i != '0) : (age < {24'd0, window_i}));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (job_valid_i) state_d = BK_SCAN;
      BK_SCAN:   if (last_idx)    state_d = BK_COMMIT;
      BK_COMMIT: if (out_free)    state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    job_pop_o = 1'b0;
    scan_en   = 1'b0;
    commit    = 1'b0;
    unique case (state_q)
      BK_IDLE:   job_pop_o = job_valid_i;
      BK_SCAN:   scan_en   = 1'b1;
      BK_COMMIT: commit    = out_free;
      default:   ;
    endcase
  end

  assign ring_wr = commit && !dup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Job capture and the running duplicate flag.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
      idx_q <= '0;
      dup_q <= 1'b0;
    end else if (scan_en) begin
      idx_q <= last_idx ? '0 : idx_q + 1'b1;
      dup_q <= dup_q | hit;
    end
  end

  // Ring contents and write slot; the ring starts out all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      for (int i = 0; i < RECENT_ENTRIES; i++) begin
        ring_hash_q[i] <= '0;
        ring_time_q[i] <= '0;
      end
    end else if (ring_wr) begin
      ring_hash_q[slot_q] <= job_q.hash;
      ring_time_q[slot_q] <= job_q.stamp;
      slot_q <= (slot_q == SLOT_W'(RECENT_ENTRIES - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      report_q   <= !dup_q;
      hash_out_q <= job_q.hash;
    end
  end

  assign empty        = !out_valid_q;
  assign report_o     = report_q;
  assign event_hash_o = hash_out_q;

  // The write slot always points inside the ring.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SLOT_W'(RECENT_ENTRIES))
    else $error("write slot outside the ring");

  // A ring write moves the slot on by one, wrapping at the end.
  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_wr |=> ((($past(slot_q) == SLOT_W'(RECENT_ENTRIES - 1)) && (slot_q == '0)) ||
                 (($past(slot_q) != SLOT_W'(RECENT_ENTRIES - 1)) &&
                  (slot_q == $past(slot_q) + 1'b1))))
    else $error("write slot did not advance");

  // A job is taken from the queue only when one is waiting.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> job_valid_i)
    else $error("job taken from an empty queue");

  // A new result is never loaded over one that has not been popped.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && out_valid_q) |-> pop)
    else $error("result overwritten before pop");

endmodule

// ===== rtl/core/path_event_dedup_filter.sv =====
// ----------------------------------------------------------------------------
// path_event_dedup_filter
// FNV-1a hash of each path with suppression of repeats inside a time window.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake       Word
//  input     in         push / full     path_byte, is_last, kind_code, time_ms
//  result    out        empty / pop     report, event_hash
//  config    in         cfg_we_i        cfg_idx_i, cfg_wdata_i
//
//  A path byte is taken in every cycle while the job queue has room.
//  Each finished path is compared against the ring one entry a cycle and then
//  committed; the two-word queue absorbs bursts.
//  Reset clears the hash, the ring, the write slot and the result valid flag.
//  A result waiting to be popped stalls the ring search and, once the queue fills, the input.
// ----------------------------------------------------------------------------
module path_event_dedup_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  path_byte_i,
  input  logic        is_last_i,
  input  logic [7:0]  kind_code_i,
  input  logic [39:0] time_ms_i,
  output logic        empty,
  input  logic        pop,
  output logic        report_o,
  output logic [31:0] event_hash_o
);
  import pedf_pkg::*;

  logic             enabled_q;
  logic [WIN_W-1:0] window_q;
  logic             job_push, job_full, job_pop, job_valid;
  job_t             job_in, job_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      window_q  <= WINDOW_INIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLED: enabled_q <= cfg_wdata_i[0];
        CFG_WINDOW:  window_q  <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // Hashing front.
  pedf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enabled_i   (enabled_q),
    .push        (push),
    .full        (full),
    .path_byte_i (path_byte_i),
    .is_last_i   (is_last_i),
    .kind_code_i (kind_code_i),
    .time_ms_i   (time_ms_i),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  // Queue of finished paths.
  pedf_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .valid_o (job_valid)
  );

  // Ring search and result register.
  pedf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .window_i     (window_q),
    .job_valid_i  (job_valid),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .empty        (empty),
    .pop          (pop),
    .report_o     (report_o),
    .event_hash_o (event_hash_o)
  );

endmodule

// ===== sim/path_event_dedup_filter_tb.sv =====
// ----------------------------------------------------------------------------
// path_event_dedup_filter_tb
// Self-checking bench for the path hash filter with repeat suppression.
// A short table of directed words (register extremes, time running
// backwards, zero bytes, a disabled filter) is followed by random paths
// drawn from a small pool, so that repeats, suppression and ring eviction
// all occur. Every popped word is checked against an in-bench predictor of
// the hash, the ring of recent events and the window compare.
// ----------------------------------------------------------------------------
module path_event_dedup_filter_tb;
  import pedf_pkg::*;

  localparam int unsigned WORD_TARGET   = 1500;
  localparam int unsigned PHASE_WORDS   = 200;
  localparam int unsigned SETTLE_CYCLES = 4 * (RECENT_ENTRIES + 2);
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned POOL_MAX      = 40;
  localparam int unsigned PATH_MAX      = 20;

  // Hash of the one-byte path "a" with kind code zero.
  localparam logic [HASH_W-1:0] HASH_A = 32'hE40C292C;

  typedef enum logic [1:0] {
    BY_MODEL,
    NO_RESULT,
    FIXED
  } row_check_e;

  typedef enum logic {
    ROW_WORD,
    ROW_SET
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              idx;
    logic [15:0]       data;
    logic [7:0]        pbyte;
    logic              last;
    logic [7:0]        kcode;
    logic [TIME_W-1:0] stamp;
    row_check_e        check;
    logic              report;
    logic [HASH_W-1:0] hash;
  } dir_row_t;

  typedef struct packed {
    logic              report;
    logic [HASH_W-1:0] hash;
  } event_t;

  // Block ports.
  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [15:0]       cfg_wdata_i;
  logic              push;
  logic              full;
  logic [7:0]        path_byte_i;
  logic              is_last_i;
  logic [7:0]        kind_code_i;
  logic [TIME_W-1:0] time_ms_i;
  logic              empty;
  logic              pop;
  logic              report_o;
  logic [HASH_W-1:0] event_hash_o;

  // Predictor state and settings.
  logic [HASH_W-1:0] acc_hash;
  logic [HASH_W-1:0] ring_hash [RECENT_ENTRIES];
  logic [TIME_W-1:0] ring_time [RECENT_ENTRIES];
  int unsigned       ring_slot;
  logic              cfg_enabled;
  logic [WIN_W-1:0]  cfg_window;

  // Expected events in order, stimulus pool and run statistics.
  event_t            pending_events [$];
  dir_row_t          dir_rows [$];
  logic [7:0]        pool_bytes [POOL_MAX][PATH_MAX];
  int unsigned       pool_len [POOL_MAX];
  logic [7:0]        pool_kind [POOL_MAX];
  logic [TIME_W-1:0] t_now;
  int unsigned       snd_gap_max = 10;
  int unsigned       rcv_gap_max = 10;
  int unsigned       n_words     = 0;
  int unsigned       n_results   = 0;
  int unsigned       n_dropped   = 0;
  int unsigned       n_writes    = 0;
  int unsigned       n_errors    = 0;
  int unsigned       n_cycles    = 0;

  path_event_dedup_filter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .path_byte_i  (path_byte_i),
    .is_last_i    (is_last_i),
    .kind_code_i  (kind_code_i),
    .time_ms_i    (time_ms_i),
    .empty        (empty),
    .pop          (pop),
    .report_o     (report_o),
    .event_hash_o (event_hash_o)
  );

  // Clock with a period of 8.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles with %0d words still expected",
               $time, n_cycles, pending_events.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Fold one accepted word into the predicted state; on a last byte while
  // enabled, give the expected event and update the ring as the block does.
  function automatic void predict_event(input logic [7:0] pb, input logic last,
                                        input logic [7:0] kc,
                                        input logic [TIME_W-1:0] ts,
                                        output logic has, output logic rep,
                                        output logic [HASH_W-1:0] h);
    logic [TIME_W-1:0] age;
    logic              seen;
    h    = (acc_hash ^ {24'd0, pb}) * FNV_PRIME;
    has  = 1'b0;
    rep  = 1'b0;
    seen = 1'b0;
    if (!last) begin
      acc_hash = h;
      return;
    end
    acc_hash = FNV_BASIS;
    if (!cfg_enabled) return;
    h = h ^ {24'd0, kc};
    // An entry stamped later than now counts as age zero.
    for (int i = 0; i < RECENT_ENTRIES; i++) begin
      if (ring_hash[i] == h) begin
        age = (ts >= ring_time[i]) ? ts - ring_time[i] : '0;
        if (age < {{(TIME_W-WIN_W){1'b0}}, cfg_window}) seen = 1'b1;
      end
    end
    if (!seen) begin
      ring_hash[ring_slot] = h;
      ring_time[ring_slot] = ts;
      ring_slot = (ring_slot == RECENT_ENTRIES - 1) ? 0 : ring_slot + 1;
    end
    has = 1'b1;
    rep = !seen;
  endfunction

  function automatic void add_word(input logic [7:0] pb, input logic last,
                                   input logic [7:0] kc, input logic [TIME_W-1:0] ts,
                                   input row_check_e chk, input logic rep,
                                   input logic [HASH_W-1:0] h);
    dir_row_t row;
    row        = '0;
    row.kind   = ROW_WORD;
    row.pbyte  = pb;
    row.last   = last;
    row.kcode  = kc;
    row.stamp  = ts;
    row.check  = chk;
    row.report = rep;
    row.hash   = h;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_set(input logic idx, input logic [15:0] val);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_SET;
    row.idx  = idx;
    row.data = val;
    dir_rows.push_back(row);
  endfunction

  // Stop offering words until every expected word has been popped, then let
  // the block run on for as many further edges as extra asks for.
  task automatic settle(input int unsigned extra);
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic idx, input logic [15:0] val);
    settle(SETTLE_CYCLES);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ENABLED) cfg_enabled = val[0];
    else cfg_window = val;
    n_writes++;
  endtask

  // Offer one input word after a random gap and record what it should cause.
  task automatic send_word(input logic [7:0] pb, input logic last,
                           input logic [7:0] kc, input logic [TIME_W-1:0] ts,
                           input row_check_e chk, input logic fix_rep,
                           input logic [HASH_W-1:0] fix_hash);
    int unsigned       gap;
    logic              has;
    logic              rep;
    logic [HASH_W-1:0] h;
    gap = $urandom_range(0, snd_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    path_byte_i <= pb;
    is_last_i   <= last;
    kind_code_i <= kc;
    time_ms_i   <= ts;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    n_words++;
    predict_event(pb, last, kc, ts, has, rep, h);
    case (chk)
      BY_MODEL: if (has) pending_events.push_back('{report: rep, hash: h});
      FIXED:    pending_events.push_back('{report: fix_rep, hash: fix_hash});
      default: ;
    endcase
  endtask

  // Result side: random pops, one long hold-off, and the check of each word.
  initial begin : result_side
    int unsigned gap;
    bit          held;
    event_t      want;
    held = 1'b0;
    pop  = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, rcv_gap_max);
      // Hold off long enough for the block to fill and stall its input.
      if (!held && n_results >= 120) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (pending_events.size() == 0) begin
        n_errors++;
        $display("%0t: word popped with none expected: report %0b hash %08h",
                 $time, report_o, event_hash_o);
      end else begin
        want = pending_events.pop_front();
        if (report_o !== want.report) begin
          n_errors++;
          $display("%0t: report mismatch: expected %0b, actual %0b",
                   $time, want.report, report_o);
        end
        if (event_hash_o !== want.hash) begin
          n_errors++;
          $display("%0t: event_hash mismatch: expected %08h, actual %08h",
                   $time, want.hash, event_hash_o);
        end
      end
      n_results++;
      if (report_o === 1'b0) n_dropped++;
      // Change the pop pattern now and then, including stretches of no gaps.
      if (n_results % 50 == 0) rcv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
    end
  end

  // Stimulus side.
  initial begin : word_side
    int unsigned phase;
    int unsigned p;
    int unsigned n;
    int unsigned pool_n;
    int unsigned n_dir;
    int unsigned phase_start;
    logic        en;
    logic [15:0] win;
    logic        last;
    bit          paused;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ENABLED;
    cfg_wdata_i = '0;
    push        = 1'b0;
    path_byte_i = '0;
    is_last_i   = 1'b0;
    kind_code_i = '0;
    time_ms_i   = '0;
    paused      = 1'b0;

    // Predictor starts from the reset state.
    acc_hash    = FNV_BASIS;
    ring_slot   = 0;
    cfg_enabled = 1'b0;
    cfg_window  = WINDOW_INIT;
    for (int i = 0; i < RECENT_ENTRIES; i++) begin
      ring_hash[i] = '0;
      ring_time[i] = '0;
    end

    // Directed table. Disabled after reset: a last byte gives nothing, and a
    // disabled path must still leave the hash back at the offset basis.
    add_word(8'h61, 1'b1, 8'h00, 40'd0, NO_RESULT, 1'b0, '0);
    add_word(8'h12, 1'b0, 8'hC3, 40'd77, BY_MODEL, 1'b0, '0);
    add_word(8'h34, 1'b1, 8'h3C, 40'd78, NO_RESULT, 1'b0, '0);
    // Enable with every data bit set; only bit 0 counts.
    add_set(CFG_ENABLED, 16'hFFFF);
    // Reset window: new at 0, repeat just inside, repeat just outside.
    add_word(8'h61, 1'b1, 8'h00, 40'd0, FIXED, 1'b1, HASH_A);
    add_word(8'h61, 1'b1, 8'h00, 40'd1199, FIXED, 1'b0, HASH_A);
    add_word(8'h61, 1'b1, 8'h00, 40'd1200, FIXED, 1'b1, HASH_A);
    // Time running backwards counts as age zero.
    add_word(8'h61, 1'b1, 8'h00, 40'd5, FIXED, 1'b0, HASH_A);
    add_word(8'h61, 1'b1, 8'h77, 40'd1300, BY_MODEL, 1'b0, '0);
    // Zero bytes are hashed and do not end a path; largest time stamp.
    add_word(8'h00, 1'b0, 8'hFF, 40'h00_0000_0000, BY_MODEL, 1'b0, '0);
    add_word(8'h00, 1'b0, 8'h00, 40'hFF_FFFF_FFFF, BY_MODEL, 1'b0, '0);
    add_word(8'h00, 1'b1, 8'hFF, 40'hFF_FFFF_FFFF, BY_MODEL, 1'b0, '0);
    add_word(8'hFF, 1'b1, 8'hFF, 40'hFF_FFFF_FFFF, BY_MODEL, 1'b0, '0);
    add_word(8'hFF, 1'b1, 8'hFF, 40'hFF_FFFF_FFFF, BY_MODEL, 1'b0, '0);
    // A zero window never suppresses.
    add_set(CFG_WINDOW, 16'h0000);
    add_word(8'h61, 1'b1, 8'h00, 40'hFF_FFFF_FFFF, FIXED, 1'b1, HASH_A);
    add_word(8'h61, 1'b1, 8'h00, 40'hFF_FFFF_FFFF, FIXED, 1'b1, HASH_A);
    // Widest window: the same path at the same time is a repeat.
    add_set(CFG_WINDOW, 16'hFFFF);
    add_word(8'h61, 1'b1, 8'h00, 40'hFF_FFFF_FFFF, FIXED, 1'b0, HASH_A);
    // Disable with the upper data bits set.
    add_set(CFG_ENABLED, 16'hFFFE);
    add_word(8'h55, 1'b1, 8'hAA, 40'hFF_FFFF_FFFF, NO_RESULT, 1'b0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_SET) begin
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_word(dir_rows[r].pbyte, dir_rows[r].last, dir_rows[r].kcode,
                  dir_rows[r].stamp, dir_rows[r].check, dir_rows[r].report,
                  dir_rows[r].hash);
      end
    end
    n_dir = n_words;

    // Random phases, each with its own settings and pool of paths.
    for (phase = 0; n_words < n_dir + WORD_TARGET; phase++) begin
      case (phase)
        0: begin en = 1'b1; win = WINDOW_INIT; end
        1: begin en = 1'b1; win = 16'h0000;    end
        2: begin en = 1'b1; win = 16'hFFFF;    end
        3: begin en = 1'b0; win = 16'($urandom); end
        default: begin
          en  = ($urandom_range(0, 6) != 0);
          win = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(1, 3000));
        end
      endcase
      write_reg(CFG_ENABLED, {15'($urandom), en});
      write_reg(CFG_WINDOW, win);
      snd_gap_max = (phase % 3 == 1) ? 0 : 10;

      // A pool drawn larger than the ring forces eviction of older entries.
      pool_n = $urandom_range(2, POOL_MAX);
      for (int i = 0; i < pool_n; i++) begin
        pool_len[i]  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, PATH_MAX)
                                                   : $urandom_range(1, 6);
        pool_kind[i] = 8'($urandom);
        for (int k = 0; k < PATH_MAX; k++) pool_bytes[i][k] = 8'($urandom);
      end
      t_now = {8'($urandom), 32'($urandom)};

      phase_start = n_words;
      while (n_words - phase_start < PHASE_WORDS && n_words < n_dir + WORD_TARGET) begin
        // Now and then the clock runs backwards.
        t_now = ($urandom_range(0, 19) == 0) ? t_now - $urandom_range(1, 3000)
                                             : t_now + $urandom_range(0, 500);
        if ($urandom_range(0, 9) == 0) begin
          // Noise: loose bytes with a random end marker.
          n = $urandom_range(1, 3);
          repeat (n) begin
            send_word(8'($urandom), 1'($urandom), 8'($urandom), t_now,
                      BY_MODEL, 1'b0, '0);
          end
        end else begin
          // A whole path from the pool; the kind and time on earlier bytes
          // must be ignored.
          p = $urandom_range(0, pool_n - 1);
          for (int k = 0; k < pool_len[p]; k++) begin
            last = (k == pool_len[p] - 1);
            send_word(pool_bytes[p][k], last,
                      last ? pool_kind[p] : 8'($urandom),
                      last ? t_now : {8'($urandom), 32'($urandom)},
                      BY_MODEL, 1'b0, '0);
          end
        end
        // Once, halfway through, let the block run completely dry.
        if (!paused && n_words >= n_dir + WORD_TARGET / 2) begin
          paused = 1'b1;
          settle(1);
        end
      end
    end

    settle(SETTLE_CYCLES);
    $display("Run covered %0d input words (%0d directed) and %0d events, %0d suppressed.",
             n_words, n_dir, n_results, n_dropped);
    $display("Settings changed %0d times over %0d random phases; %0d mismatches.",
             n_writes, phase, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
